// ----- rtl/csl_pkg.sv -----
package csl_pkg;

  // Token kinds as they appear on the result channel
  localparam logic [5:0] K_STR        = 6'd0;
  localparam logic [5:0] K_POPEN      = 6'd1;
  localparam logic [5:0] K_PCLOSE     = 6'd2;
  localparam logic [5:0] K_COPEN      = 6'd3;
  localparam logic [5:0] K_CCLOSE     = 6'd4;
  localparam logic [5:0] K_COLON      = 6'd5;
  localparam logic [5:0] K_SEMI       = 6'd6;
  localparam logic [5:0] K_DOT        = 6'd7;
  localparam logic [5:0] K_COMMA      = 6'd8;
  localparam logic [5:0] K_EQ         = 6'd9;
  localparam logic [5:0] K_LT         = 6'd10;
  localparam logic [5:0] K_GT         = 6'd11;
  localparam logic [5:0] K_NOT        = 6'd12;
  localparam logic [5:0] K_AMP        = 6'd13;
  localparam logic [5:0] K_BAR        = 6'd14;
  localparam logic [5:0] K_PLUS       = 6'd15;
  localparam logic [5:0] K_MINUS      = 6'd16;
  localparam logic [5:0] K_STAR       = 6'd17;
  localparam logic [5:0] K_SLASH      = 6'd18;
  localparam logic [5:0] K_PCT        = 6'd19;
  localparam logic [5:0] K_IDENT      = 6'd20;
  localparam logic [5:0] K_INT        = 6'd21;
  localparam logic [5:0] K_FLOAT      = 6'd22;
  localparam logic [5:0] K_EQ_EQ      = 6'd23;
  localparam logic [5:0] K_LT_EQ      = 6'd24;
  localparam logic [5:0] K_GT_EQ      = 6'd25;
  localparam logic [5:0] K_NOT_EQ     = 6'd26;
  localparam logic [5:0] K_PLUS_EQ    = 6'd27;
  localparam logic [5:0] K_MINUS_EQ   = 6'd28;
  localparam logic [5:0] K_STAR_EQ    = 6'd29;
  localparam logic [5:0] K_SLASH_EQ   = 6'd30;
  localparam logic [5:0] K_AND        = 6'd31;
  localparam logic [5:0] K_OR         = 6'd32;
  localparam logic [5:0] K_INCR       = 6'd33;
  localparam logic [5:0] K_DECR       = 6'd34;
  localparam logic [5:0] K_EXP        = 6'd35;
  localparam logic [5:0] K_FLOORDIV   = 6'd36;
  localparam logic [5:0] K_KW0        = 6'd37;
  localparam logic [5:0] K_NONE       = 6'd52;
  // Internal only: whitespace run and unknown byte
  localparam logic [5:0] K_WS         = 6'd53;
  localparam logic [5:0] K_BAD        = 6'd63;

  localparam int KEYWORD_CHARS_DEF = 8;
  localparam int KW_MAX_CHARS      = 8;
  localparam int KW_COUNT          = 15;

  // Result queue depth, power of two
  localparam int QDEPTH = 8;

  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    64'("return"), 64'("if"), 64'("else"), 64'("for"), 64'("while"),
    64'("switch"), 64'("case"), 64'("break"), 64'("default"), 64'("continue"),
    64'("null"), 64'("true"), 64'("false"), 64'("enum"), 64'("struct")
  };
  localparam int KW_LEN [KW_COUNT] = '{6, 2, 4, 3, 5, 6, 4, 5, 7, 8, 4, 4, 5, 4, 6};

  typedef struct packed {
    logic       valid;
    logic [7:0] char_code;
    logic       last_char;
  } item_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [31:0] token_start;
    logic [15:0] token_length;
    logic        is_error;
    logic [31:0] line_number;
    logic        stream_done;
  } res_t;

  typedef struct packed {
    logic push0;
    logic push1;
    res_t res0;
    res_t res1;
  } push_t;

  // Class of a byte outside quote mode
  function automatic logic [5:0] char_class(logic [7:0] c);
    logic [5:0] k;
    case (c)
      8'h0A, 8'h0D, 8'h09, " ": k = K_WS;
      "(": k = K_POPEN;
      ")": k = K_PCLOSE;
      "{": k = K_COPEN;
      "}": k = K_CCLOSE;
      ":": k = K_COLON;
      ";": k = K_SEMI;
      ".": k = K_DOT;
      ",": k = K_COMMA;
      "=": k = K_EQ;
      "<": k = K_LT;
      ">": k = K_GT;
      "!": k = K_NOT;
      "&": k = K_AMP;
      "|": k = K_BAR;
      "+": k = K_PLUS;
      "-": k = K_MINUS;
      "*": k = K_STAR;
      "/": k = K_SLASH;
      "%": k = K_PCT;
      default: begin
        if (c inside {["a":"z"], ["A":"Z"], "_"}) begin
          k = K_IDENT;
        end else if (c inside {["0":"9"]}) begin
          k = K_INT;
        end else begin
          k = K_BAD;
        end
      end
    endcase
    return k;
  endfunction

  function automatic logic [5:0] with_equals(logic [5:0] k);
    logic [5:0] r;
    case (k)
      K_EQ:    r = K_EQ_EQ;
      K_LT:    r = K_LT_EQ;
      K_GT:    r = K_GT_EQ;
      K_NOT:   r = K_NOT_EQ;
      K_PLUS:  r = K_PLUS_EQ;
      K_MINUS: r = K_MINUS_EQ;
      K_STAR:  r = K_STAR_EQ;
      K_SLASH: r = K_SLASH_EQ;
      default: r = k;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] doubled(logic [5:0] k);
    logic [5:0] r;
    case (k)
      K_AMP:   r = K_AND;
      K_BAR:   r = K_OR;
      K_PLUS:  r = K_INCR;
      K_MINUS: r = K_DECR;
      K_STAR:  r = K_EXP;
      K_SLASH: r = K_FLOORDIV;
      default: r = k;
    endcase
    return r;
  endfunction

  // head holds the first word bytes, byte j at [8*j +: 8]
  function automatic logic [5:0] kw_lookup(logic [15:0] len, logic [63:0] head);
    logic [5:0] k;
    logic       hit;
    k = K_IDENT;
    for (int i = 0; i < KW_COUNT; i++) begin
      hit = (len == 16'(KW_LEN[i]));
      for (int j = 0; j < KW_MAX_CHARS; j++) begin
        if (j < KW_LEN[i]) begin
          hit = hit && (head[8*j +: 8] == KW_TEXT[i][8*(KW_LEN[i]-1-j) +: 8]);
        end
      end
      if (hit) begin
        k = K_KW0 + 6'(i);
      end
    end
    return k;
  endfunction

endpackage

// ----- rtl/csl_stream_if.sv -----
interface csl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface csl_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [31:0] token_start;
  logic [15:0] token_length;
  logic        is_error;
  logic [31:0] line_number;
  logic        stream_done;

  modport source (output valid, output token_kind, output token_start, output token_length,
                  output is_error, output line_number, output stream_done, input ready);
  modport sink   (input valid, input token_kind, input token_start, input token_length,
                  input is_error, input line_number, input stream_done, output ready);
endinterface

// ----- rtl/csl_in_stage.sv -----
module csl_in_stage (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  csl_in_if.sink                          char_i,
  input  logic [$clog2(csl_pkg::QDEPTH):0] q_count_i,
  output csl_pkg::item_t                  item_o
);
  import csl_pkg::*;

  localparam int CW = $clog2(QDEPTH) + 1;

  logic         vld_q;
  logic [7:0]   char_q;
  logic         last_q;
  logic [CW:0]  load;

  // Reserve two queue slots for every byte that may still push results
  assign load         = (CW+1)'(q_count_i) + (CW+1)'({vld_q, 1'b0});
  assign char_i.ready = (load <= (CW+1)'(QDEPTH - 2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= char_i.valid && char_i.ready;
    end
  end

  always_ff @(posedge clk_i) begin
    if (char_i.valid && char_i.ready) begin
      char_q <= char_i.char_code;
      last_q <= char_i.last_char;
    end
  end

  assign item_o = '{valid: vld_q, char_code: char_q, last_char: last_q};

endmodule

// ----- rtl/csl_engine.sv -----
module csl_engine #(
  parameter int KEYWORD_CHARS = csl_pkg::KEYWORD_CHARS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  csl_pkg::item_t item_i,
  output csl_pkg::push_t push_o
);
  import csl_pkg::*;

  localparam int IW = $clog2(KEYWORD_CHARS);

  logic        quote_q, quote_d;
  logic [31:0] line_q, line_d;
  logic [31:0] pos_q, pos_d;
  logic [5:0]  pk_q, pk_d;
  logic [31:0] pstart_q, pstart_d;
  logic [15:0] plen_q, plen_d;
  logic        halt_q, halt_d;
  logic [7:0]  wbuf_q [KEYWORD_CHARS];
  logic [7:0]  wbuf_n [KEYWORD_CHARS];

  logic [7:0]  c;
  logic [5:0]  cls;
  logic        quote_n;
  logic [31:0] line_n;
  logic        merge;
  logic [5:0]  pk_m;
  logic [15:0] base_len, len_e;
  logic [31:0] start_m;
  logic        wr_en;
  logic [IW-1:0] wr_idx;
  logic [63:0] head_old, head_new;
  logic        close_old, flush;
  res_t        close_res, flush_res, end_res, err_res;
  logic [5:0]  close_kind, flush_kind;

  always_comb begin
    c       = item_i.char_code;
    quote_n = quote_q;
    line_n  = line_q;
    if (c == "'" || c == "\"") begin
      quote_n = ~quote_q;
      cls     = K_STR;
    end else if (quote_q) begin
      cls = K_STR;
    end else begin
      cls = char_class(c);
      if (c == 8'h0A && line_q != '1) begin
        line_n = line_q + 32'd1;
      end
    end

    // Extend the pending token or start a new one
    if (cls == K_EQ && with_equals(pk_q) != pk_q) begin
      merge = 1'b1;
      pk_m  = with_equals(pk_q);
    end else if (pk_q == K_INT && cls == K_DOT) begin
      merge = 1'b1;
      pk_m  = K_FLOAT;
    end else if (cls == pk_q || ((pk_q == K_IDENT || pk_q == K_FLOAT) && cls == K_INT)) begin
      merge = 1'b1;
      pk_m  = doubled(pk_q);
    end else begin
      merge = 1'b0;
      pk_m  = cls;
    end

    base_len = merge ? plen_q : 16'd0;
    len_e    = (base_len == 16'hFFFF) ? base_len : base_len + 16'd1;
    start_m  = merge ? pstart_q : pos_q;
    wr_en    = (pk_m == K_IDENT) && (base_len < 16'(KEYWORD_CHARS));
    wr_idx   = base_len[IW-1:0];

    wbuf_n = wbuf_q;
    if (wr_en) begin
      wbuf_n[wr_idx] = c;
    end
    for (int j = 0; j < KW_MAX_CHARS; j++) begin
      head_old[8*j +: 8] = wbuf_q[j];
      head_new[8*j +: 8] = wbuf_n[j];
    end

    if (pk_q == K_IDENT && plen_q <= 16'(KEYWORD_CHARS)) begin
      close_kind = kw_lookup(plen_q, head_old);
    end else begin
      close_kind = pk_q;
    end
    if (pk_m == K_IDENT && len_e <= 16'(KEYWORD_CHARS)) begin
      flush_kind = kw_lookup(len_e, head_new);
    end else begin
      flush_kind = pk_m;
    end

    close_old = !merge && (pk_q != K_WS);
    flush     = item_i.last_char && (pk_m != K_WS);

    close_res = '{token_kind: close_kind, token_start: pstart_q, token_length: plen_q,
                  is_error: 1'b0, line_number: line_n,
                  stream_done: item_i.last_char && !flush};
    flush_res = '{token_kind: flush_kind, token_start: start_m, token_length: len_e,
                  is_error: 1'b0, line_number: line_n, stream_done: 1'b1};
    end_res   = '{token_kind: K_NONE, token_start: 32'd0, token_length: 16'd0,
                  is_error: 1'b0, line_number: line_n, stream_done: 1'b1};
    err_res   = '{token_kind: K_NONE, token_start: pos_q, token_length: 16'd1,
                  is_error: 1'b1, line_number: line_n, stream_done: 1'b1};

    push_o = '{push0: 1'b0, push1: 1'b0, res0: close_res, res1: flush_res};
    quote_d  = quote_q;
    line_d   = line_q;
    pos_d    = pos_q;
    pk_d     = pk_q;
    pstart_d = pstart_q;
    plen_d   = plen_q;
    halt_d   = halt_q;

    if (item_i.valid && !halt_q) begin
      pos_d = pos_q + 32'd1;
      if (cls == K_BAD) begin
        push_o.push0 = 1'b1;
        push_o.res0  = err_res;
        halt_d       = 1'b1;
      end else begin
        if (close_old) begin
          push_o.push0 = 1'b1;
          push_o.push1 = flush;
        end else if (flush) begin
          push_o.push0 = 1'b1;
          push_o.res0  = flush_res;
        end else if (item_i.last_char) begin
          push_o.push0 = 1'b1;
          push_o.res0  = end_res;
        end
        if (item_i.last_char) begin
          // End of stream: back to reset values
          quote_d  = 1'b0;
          line_d   = 32'd1;
          pos_d    = 32'd0;
          pk_d     = K_WS;
          pstart_d = 32'd0;
          plen_d   = 16'd0;
        end else begin
          quote_d  = quote_n;
          line_d   = line_n;
          pk_d     = pk_m;
          pstart_d = start_m;
          plen_d   = len_e;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quote_q  <= 1'b0;
      line_q   <= 32'd1;
      pos_q    <= 32'd0;
      pk_q     <= K_WS;
      pstart_q <= 32'd0;
      plen_q   <= 16'd0;
      halt_q   <= 1'b0;
    end else begin
      quote_q  <= quote_d;
      line_q   <= line_d;
      pos_q    <= pos_d;
      pk_q     <= pk_d;
      pstart_q <= pstart_d;
      plen_q   <= plen_d;
      halt_q   <= halt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && !halt_q && wr_en) begin
      wbuf_q[wr_idx] <= c;
    end
  end

endmodule

// ----- rtl/csl_res_fifo.sv -----
module csl_res_fifo (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  csl_pkg::push_t                   push_i,
  input  logic                             pop_i,
  output logic                             valid_o,
  output csl_pkg::res_t                    head_o,
  output logic [$clog2(csl_pkg::QDEPTH):0] count_o
);
  import csl_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  res_t          mem [QDEPTH];
  logic [PW-1:0] wp_q, wp_d;
  logic [PW-1:0] rp_q, rp_d;
  logic [PW:0]   cnt_q, cnt_d;

  always_comb begin
    wp_d  = wp_q + PW'(push_i.push0) + PW'(push_i.push1);
    rp_d  = rp_q + PW'(pop_i);
    cnt_d = cnt_q + (PW+1)'(push_i.push0) + (PW+1)'(push_i.push1) - (PW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push0) begin
      mem[wp_q] <= push_i.res0;
    end
    if (push_i.push1) begin
      mem[wp_q + PW'(1)] <= push_i.res1;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign head_o  = mem[rp_q];
  assign count_o = cnt_q;

endmodule

// ----- rtl/char_stream_lexer_top.sv -----
// Character stream lexer.
// char_i takes one source byte per transfer with last_char marking the final
// byte of a stream. token_o gives closed tokens as kind, start offset, length,
// error flag, current line and stream_done; whitespace runs give no token.
// A byte yields zero, one or two tokens; the final byte of a stream always
// yields at least one (an end marker with kind 52 when nothing else closes).
// A transferred byte is held in the input register, where it is classified
// and merged against the pending token; its tokens are written to the result
// queue at the next edge and are valid on token_o from then on.
// Throughput: one byte per cycle while char_i.ready is high. Tokens leave
// through an eight-entry result queue, one per cycle while the receiver is
// ready; char_i.ready drops unless the queue keeps two free entries for the
// byte on offer and two more for the byte in the input register when it holds
// one, so a stalled receiver backs up into char_i without losing or repeating
// a token.
// An unknown byte outside quotes gives one error token and the block then
// drops every byte until reset.
// Reset clears quote mode, line count (to 1), byte offset, pending token, the
// halt flag and the result queue; the block accepts bytes right after reset.
module char_stream_lexer_top #(
  parameter int KEYWORD_CHARS = csl_pkg::KEYWORD_CHARS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  csl_in_if.sink   char_i,
  csl_out_if.source token_o
);
  import csl_pkg::*;

  item_t                    item;
  push_t                    push;
  res_t                     head;
  logic                     q_valid;
  logic [$clog2(QDEPTH):0]  q_count;

  csl_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .char_i    (char_i),
    .q_count_i (q_count),
    .item_o    (item)
  );

  csl_engine #(
    .KEYWORD_CHARS (KEYWORD_CHARS)
  ) u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item),
    .push_o (push)
  );

  csl_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (q_valid && token_o.ready),
    .valid_o (q_valid),
    .head_o  (head),
    .count_o (q_count)
  );

  assign token_o.valid        = q_valid;
  assign token_o.token_kind   = head.token_kind;
  assign token_o.token_start  = head.token_start;
  assign token_o.token_length = head.token_length;
  assign token_o.is_error     = head.is_error;
  assign token_o.line_number  = head.line_number;
  assign token_o.stream_done  = head.stream_done;

endmodule

// ----- rtl/csl_checker.sv -----
module csl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [5:0]  token_kind_i,
  input logic [15:0] token_length_i,
  input logic [31:0] token_start_i,
  input logic        is_error_i,
  input logic        stream_done_i
);
  import csl_pkg::*;

  logic out_xfer;
  assign out_xfer = out_valid_i && out_ready_i;

  // Stalled token holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(token_kind_i)
      && $stable(token_start_i) && $stable(token_length_i))
    else $error("token changed while stalled");

  // Halt after an unknown byte: nothing follows the error token
  a_halt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && is_error_i |=> !out_valid_i)
    else $error("token after error");

  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && is_error_i |-> token_kind_i == K_NONE && token_length_i == 16'd1
      && stream_done_i)
    else $error("malformed error token");

  a_end_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !is_error_i && token_kind_i == K_NONE |->
      token_length_i == 16'd0 && token_start_i == 32'd0 && stream_done_i)
    else $error("malformed end marker");

endmodule

bind char_stream_lexer_top csl_checker u_csl_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (token_o.valid),
  .out_ready_i    (token_o.ready),
  .token_kind_i   (token_o.token_kind),
  .token_length_i (token_o.token_length),
  .token_start_i  (token_o.token_start),
  .is_error_i     (token_o.is_error),
  .stream_done_i  (token_o.stream_done)
);

// ----- dv/csl_token_checker.sv -----
module csl_token_checker #(
  parameter int KEYWORD_CHARS = csl_pkg::KEYWORD_CHARS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  csl_in_if    char_i,
  csl_out_if   token_i,
  output int   fail_cnt_o,
  output int   pending_o,
  output int   bytes_o,
  output int   tokens_o
);
  import csl_pkg::*;

  // Keyword kinds follow this order starting at K_KW0
  string keyword_list [15] = '{
    "return", "if", "else", "for", "while", "switch", "case", "break",
    "default", "continue", "null", "true", "false", "enum", "struct"
  };

  res_t        token_q[$];
  logic        quote_on;
  logic        halted;
  logic [31:0] line_no;
  logic [31:0] byte_pos;
  logic [5:0]  pend_kind;
  logic [31:0] pend_start;
  logic [15:0] pend_len;
  logic [7:0]  word_buf [KEYWORD_CHARS];

  function automatic void clear_stream();
    quote_on   = 1'b0;
    line_no    = 32'd1;
    byte_pos   = '0;
    pend_kind  = K_WS;
    pend_start = '0;
    pend_len   = '0;
    for (int i = 0; i < KEYWORD_CHARS; i++) word_buf[i] = '0;
  endfunction

  function automatic void predict_token(input res_t t);
    token_q = {token_q, t};
  endfunction

  function automatic logic [5:0] byte_class(input logic [7:0] c);
    logic [5:0] k;
    if (c == 8'h22 || c == 8'h27) begin
      quote_on = !quote_on;
      return K_STR;
    end
    if (quote_on) return K_STR;
    case (c)
      8'h0A: begin
        if (line_no != 32'hFFFF_FFFF) line_no = line_no + 32'd1;
        k = K_WS;
      end
      8'h20, 8'h0D, 8'h09: k = K_WS;
      "(": k = K_POPEN;
      ")": k = K_PCLOSE;
      "{": k = K_COPEN;
      "}": k = K_CCLOSE;
      ":": k = K_COLON;
      ";": k = K_SEMI;
      ".": k = K_DOT;
      ",": k = K_COMMA;
      "=": k = K_EQ;
      "<": k = K_LT;
      ">": k = K_GT;
      "!": k = K_NOT;
      "&": k = K_AMP;
      "|": k = K_BAR;
      "+": k = K_PLUS;
      "-": k = K_MINUS;
      "*": k = K_STAR;
      "/": k = K_SLASH;
      "%": k = K_PCT;
      default: begin
        if (c == "_" || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) begin
          k = K_IDENT;
        end else if (c >= "0" && c <= "9") begin
          k = K_INT;
        end else begin
          k = K_BAD;
        end
      end
    endcase
    return k;
  endfunction

  function automatic logic [5:0] eq_join(input logic [5:0] k);
    case (k)
      K_EQ:    return K_EQ_EQ;
      K_LT:    return K_LT_EQ;
      K_GT:    return K_GT_EQ;
      K_NOT:   return K_NOT_EQ;
      K_PLUS:  return K_PLUS_EQ;
      K_MINUS: return K_MINUS_EQ;
      K_STAR:  return K_STAR_EQ;
      K_SLASH: return K_SLASH_EQ;
      default: return k;
    endcase
  endfunction

  function automatic logic [5:0] twin_kind(input logic [5:0] k);
    case (k)
      K_AMP:   return K_AND;
      K_BAR:   return K_OR;
      K_PLUS:  return K_INCR;
      K_MINUS: return K_DECR;
      K_STAR:  return K_EXP;
      K_SLASH: return K_FLOORDIV;
      default: return k;
    endcase
  endfunction

  function automatic void grow(input logic [7:0] c);
    if (pend_kind == K_IDENT && pend_len < KEYWORD_CHARS) word_buf[pend_len] = c;
    if (pend_len != 16'hFFFF) pend_len = pend_len + 16'd1;
  endfunction

  function automatic res_t make_tok(input logic [5:0] kind, input logic [31:0] start,
                                    input logic [15:0] len, input logic err);
    res_t t;
    t.token_kind   = kind;
    t.token_start  = start;
    t.token_length = len;
    t.is_error     = err;
    t.line_number  = line_no;
    t.stream_done  = 1'b0;
    return t;
  endfunction

  // Short identifiers may turn out to be keywords once closed
  function automatic res_t closed_token();
    logic [5:0] k;
    logic       hit;
    k = pend_kind;
    if (pend_kind == K_IDENT && pend_len <= KEYWORD_CHARS) begin
      for (int i = 0; i < 15; i++) begin
        hit = (keyword_list[i].len() == int'(pend_len));
        for (int j = 0; j < keyword_list[i].len() && hit; j++) begin
          hit = (word_buf[j] == keyword_list[i][j]);
        end
        if (hit) k = K_KW0 + 6'(i);
      end
    end
    return make_tok(k, pend_start, pend_len, 1'b0);
  endfunction

  task automatic lex_byte(input logic [7:0] c, input logic last);
    res_t        toks [2];
    logic [5:0]  cls;
    logic [31:0] at;
    int          n;
    n = 0;
    if (halted) return;
    at = byte_pos;
    byte_pos = byte_pos + 32'd1;
    cls = byte_class(c);
    if (cls == K_BAD) begin
      halted = 1'b1;
      toks[0] = make_tok(K_NONE, at, 16'd1, 1'b1);
      toks[0].stream_done = 1'b1;
      predict_token(toks[0]);
      return;
    end
    if (cls == K_EQ && eq_join(pend_kind) != pend_kind) begin
      pend_kind = eq_join(pend_kind);
      grow(c);
    end else if (pend_kind == K_INT && cls == K_DOT) begin
      pend_kind = K_FLOAT;
      grow(c);
    end else if (cls == pend_kind ||
                 ((pend_kind == K_IDENT || pend_kind == K_FLOAT) && cls == K_INT)) begin
      pend_kind = twin_kind(pend_kind);
      grow(c);
    end else begin
      if (pend_kind != K_WS) begin
        toks[n] = closed_token();
        n++;
      end
      pend_kind  = cls;
      pend_start = at;
      pend_len   = '0;
      grow(c);
    end
    if (last) begin
      if (pend_kind != K_WS) begin
        toks[n] = closed_token();
        n++;
      end
      if (n == 0) begin
        toks[0] = make_tok(K_NONE, '0, '0, 1'b0);
        n = 1;
      end
      toks[n-1].stream_done = 1'b1;
      clear_stream();
    end
    for (int i = 0; i < n; i++) predict_token(toks[i]);
  endtask

  task automatic note_fail(input string msg);
    fail_cnt_o++;
    if (fail_cnt_o <= 10) $display("token mismatch: %s", msg);
  endtask

  task automatic check_token();
    res_t got;
    res_t want;
    got.token_kind   = token_i.token_kind;
    got.token_start  = token_i.token_start;
    got.token_length = token_i.token_length;
    got.is_error     = token_i.is_error;
    got.line_number  = token_i.line_number;
    got.stream_done  = token_i.stream_done;
    tokens_o++;
    if (token_q.size() == 0) begin
      note_fail($sformatf("unexpected kind %0d start %0d len %0d err %0b line %0d done %0b",
                          got.token_kind, got.token_start, got.token_length, got.is_error,
                          got.line_number, got.stream_done));
      return;
    end
    want = token_q.pop_front();
    if (got.token_kind !== want.token_kind || got.token_start !== want.token_start ||
        got.token_length !== want.token_length || got.is_error !== want.is_error ||
        got.line_number !== want.line_number || got.stream_done !== want.stream_done) begin
      note_fail($sformatf({"expected kind %0d start %0d len %0d err %0b line %0d done %0b,",
                           " got kind %0d start %0d len %0d err %0b line %0d done %0b"},
                          want.token_kind, want.token_start, want.token_length,
                          want.is_error, want.line_number, want.stream_done,
                          got.token_kind, got.token_start, got.token_length,
                          got.is_error, got.line_number, got.stream_done));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_stream();
      halted = 1'b0;
      token_q.delete();
      fail_cnt_o = 0;
      pending_o  = 0;
      bytes_o    = 0;
      tokens_o   = 0;
    end else begin
      // Retire outputs first; a byte accepted now cannot produce a token this edge
      if (token_i.valid && token_i.ready) check_token();
      if (char_i.valid && char_i.ready) begin
        bytes_o++;
        lex_byte(char_i.char_code, char_i.last_char);
      end
      pending_o = token_q.size();
    end
  end

endmodule

// ----- dv/testbench.sv -----
module testbench;
  import csl_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int STALL_CYCLES   = 150;
  localparam int DRAIN_CYCLES   = 16;
  localparam int PHASE_BYTES    = 115;

  logic clk_i;
  logic rst_ni;
  int   tx_idle_pct;
  int   rx_idle_pct;
  bit   hold_req;
  bit   hold_done;
  int   fail_cnt;
  int   pending_cnt;
  int   byte_cnt;
  int   token_cnt;

  logic [7:0] src_q[$];

  // Keywords mixed with near misses
  string words [21] = '{
    "return", "if", "else", "for", "while", "switch", "case", "break",
    "default", "continue", "null", "true", "false", "enum", "struct",
    "iff", "nul", "continues", "Return", "els", "structs"
  };
  string ops [33] = '{
    "(", ")", "{", "}", ":", ";", ".", ",", "=", "<", ">", "!", "&", "|", "+", "-",
    "*", "/", "%", "==", "<=", ">=", "!=", "+=", "-=", "*=", "/=", "&&", "||", "++",
    "--", "**", "//"
  };
  string noise = "(){}:;.,=<>!&|+-*/%_azAZ09";

  csl_in_if  char_if ();
  csl_out_if tok_if ();

  char_stream_lexer_top uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .char_i  (char_if),
    .token_o (tok_if)
  );

  csl_token_checker chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .char_i     (char_if),
    .token_i    (tok_if),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending_cnt),
    .bytes_o    (byte_cnt),
    .tokens_o   (token_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic send_byte(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      char_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    char_if.valid     <= 1'b1;
    char_if.char_code <= c;
    char_if.last_char <= last;
    @(posedge clk_i);
    while (!char_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_src(input bit close);
    for (int i = 0; i < src_q.size(); i++) begin
      send_byte(src_q[i], close && (i == src_q.size() - 1));
    end
    src_q.delete();
  endtask

  function automatic void queue_byte(input logic [7:0] b);
    src_q = {src_q, b};
  endfunction

  function automatic void push_str(input string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endfunction

  function automatic logic [7:0] ident_char(input bit first);
    int r;
    r = $urandom_range(first ? 52 : 62);
    if (r < 26) return 8'h61 + 8'(r);
    if (r < 52) return 8'h41 + 8'(r - 26);
    if (r == 52) return 8'h5F;
    return 8'h30 + 8'(r - 53);
  endfunction

  function automatic logic [7:0] space_char();
    logic [7:0] blanks [4] = '{8'h20, 8'h09, 8'h0D, 8'h0A};
    return blanks[$urandom_range(3)];
  endfunction

  function automatic logic [7:0] quote_char();
    return $urandom_range(1) ? 8'h22 : 8'h27;
  endfunction

  function automatic logic [7:0] bad_byte();
    logic [7:0] odd [8] = '{8'h00, 8'h01, 8'h1B, 8'h23, 8'h40, 8'h5C, 8'h7E, 8'h7F};
    if ($urandom_range(1)) return 8'($urandom_range(128, 255));
    return odd[$urandom_range(7)];
  endfunction

  function automatic void push_digits(input int lo, input int hi);
    repeat ($urandom_range(lo, hi)) queue_byte(8'h30 + 8'($urandom_range(9)));
  endfunction

  // Any byte but a quote inside
  function automatic void push_quoted(input bit close);
    logic [7:0] c;
    queue_byte(quote_char());
    repeat ($urandom_range(0, 6)) begin
      do c = 8'($urandom_range(255)); while (c == 8'h22 || c == 8'h27);
      queue_byte(c);
    end
    if (close) queue_byte(quote_char());
  endfunction

  function automatic void push_word();
    int n;
    case ($urandom_range(9))
      0, 1: push_str(words[$urandom_range(20)]);
      2: begin
        n = $urandom_range(1, 12);
        queue_byte(ident_char(1'b1));
        for (int i = 1; i < n; i++) queue_byte(ident_char(1'b0));
      end
      3: push_digits(1, 6);
      4: begin
        push_digits(1, 3);
        queue_byte(".");
        push_digits(0, 3);
      end
      5, 6: push_str(ops[$urandom_range(32)]);
      7: push_quoted(1'b1);
      8: repeat ($urandom_range(1, 3)) queue_byte(space_char());
      default: repeat ($urandom_range(1, 4)) queue_byte(noise[$urandom_range(noise.len() - 1)]);
    endcase
    if ($urandom_range(1)) queue_byte(space_char());
  endfunction

  task automatic run_streams(input int target);
    int sent;
    sent = 0;
    while (sent < target) begin
      repeat ($urandom_range(1, 12)) push_word();
      // Now and then end a stream inside an open string
      if ($urandom_range(9) == 0) push_quoted(1'b0);
      sent += src_q.size();
      send_src(1'b1);
    end
  endtask

  // Receiver: random backpressure plus one long hold-off
  initial begin
    tok_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        tok_if.ready <= 1'b0;
        repeat (STALL_CYCLES) @(negedge clk_i);
        hold_done = 1'b1;
      end
      tok_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((char_if.valid && char_if.ready) || (tok_if.valid && tok_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_ni            = 1'b0;
    char_if.valid     = 1'b0;
    char_if.char_code = '0;
    char_if.last_char = 1'b0;
    tx_idle_pct       = 25;
    rx_idle_pct       = 54;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Quoted extreme bytes, a newline, then a byte that closes and flushes
    src_q = '{8'h22, 8'hFF, 8'h00, 8'h27};
    push_str("\na;");
    send_src(1'b1);
    // Whitespace alone gives only the end marker
    send_byte(8'h20, 1'b1);
    push_str("for(i=0;i<=9;i++)");
    send_src(1'b1);

    run_streams(PHASE_BYTES);

    tx_idle_pct = 54;
    rx_idle_pct = 25;
    run_streams(PHASE_BYTES);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req    = 1'b1;
    run_streams(PHASE_BYTES);

    // Unknown byte mid-stream halts; everything after it is dropped
    push_str("ab+");
    send_src(1'b0);
    send_byte(bad_byte(), 1'b0);
    push_str("cd;");
    send_src(1'b1);
    char_if.valid <= 1'b0;

    while (pending_cnt != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Lexed %0d source bytes into %0d checked tokens over three backpressure mixes",
             byte_cnt, token_cnt);
    $display("and a long receiver stall, closing with an unknown-byte halt.");
    if (pending_cnt != 0) $display("%0d expected tokens never arrived", pending_cnt);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/csl_pkg.sv
rtl/csl_stream_if.sv
rtl/csl_in_stage.sv
rtl/csl_engine.sv
rtl/csl_res_fifo.sv
rtl/char_stream_lexer_top.sv
rtl/csl_checker.sv
dv/csl_token_checker.sv
dv/testbench.sv
